[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared words, command codes and byte constants of the console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // control bytes and cell values
    localparam logic [7:0]  CH_BELL      = 8'h07;
    localparam logic [7:0]  CH_BACKSPACE = 8'h08;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CH_RETURN    = 8'h0D;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [15:0] ATTR_NORMAL  = 16'h0700;
    localparam logic [15:0] BLANK_CELL   = 16'h0720;

    // command codes from the classifier
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_READ_CELL  = 4'd0;
    localparam logic [OP_W-1:0] OP_READ_BLANK = 4'd1;
    localparam logic [OP_W-1:0] OP_READ_ZERO  = 4'd2;
    localparam logic [OP_W-1:0] OP_NEWLINE    = 4'd3;
    localparam logic [OP_W-1:0] OP_RETURN     = 4'd4;
    localparam logic [OP_W-1:0] OP_TAB        = 4'd5;
    localparam logic [OP_W-1:0] OP_BACKSPACE  = 4'd6;
    localparam logic [OP_W-1:0] OP_NOP        = 4'd7;
    localparam logic [OP_W-1:0] OP_PLAIN      = 4'd8;

    // command queue size
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } req_word_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } rsp_word_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      char_code;
        logic [4:0]      read_row;
        logic [6:0]      read_col;
    } cmd_word_t;

endpackage

[rtl/core/text_console_char_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text console writer: classifier, command queue and executor with cell store.
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  req      req_valid / req_ready  kind, char_code, read_row, read_col
//  rsp      rsp_valid / rsp_ready  cell_value, cursor_row, cursor_col
//
//  A request word enters the queue at its accepting edge; the executor handles
//  a control byte, a plain byte or a read outside the store directly, reads a
//  stored cell through the registered port and writes TAB_SPACES spaces on a
//  tab, then loads the response. A newline or wrap on the bottom row scrolls
//  the store up one row first. After reset a clearing pass holds req_ready
//  low; a held response stalls the executor while the queue still takes words.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 24,
    parameter int TOTAL_ROWS  = 25,
    parameter int TAB_SPACES  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tcw_pkg::req_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcw_pkg::rsp_word_t  rsp
);
    import tcw_pkg::*;

    logic      push;
    cmd_word_t push_word;
    logic      queue_full;
    logic      queue_not_empty;
    cmd_word_t queue_head;
    logic      queue_pop;
    logic      clearing;

    // classifier
    tcw_front #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS),
        .TOTAL_ROWS  (TOTAL_ROWS)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_word  (push_word)
    );

    // command queue
    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .full      (queue_full),
        .head      (queue_head)
    );

    // executor
    tcw_back #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS),
        .TAB_SPACES  (TAB_SPACES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_head),
        .cmd_pop   (queue_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[rtl/core/tcw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request words and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 24,
    parameter int TOTAL_ROWS  = 25
) (
    input  logic                req_valid,
    output logic                req_ready,
    input  tcw_pkg::req_word_t  req,
    input  logic                queue_full,
    input  logic                clearing,
    output logic                push,
    output tcw_pkg::cmd_word_t  push_word
);
    import tcw_pkg::*;

    logic row_in_range;
    logic col_in_range;
    logic row_unwritten;

    // range checks on the read address
    assign row_in_range  = 32'(req.read_row) < 32'(TOTAL_ROWS);
    assign col_in_range  = 32'(req.read_col) < 32'(COLUMNS);
    assign row_unwritten = 32'(req.read_row) >= 32'(SCROLL_ROWS);

    // hold off while the queue is full or the store is being cleared
    assign req_ready = !queue_full && !clearing;
    assign push      = req_valid && req_ready;

    // classify the word
    always_comb
    begin
        push_word.char_code = req.char_code;
        push_word.read_row  = req.read_row;
        push_word.read_col  = req.read_col;
        push_word.op        = OP_NOP;
        if (req.kind == KIND_READ)
        begin
            if (!(row_in_range && col_in_range))
                push_word.op = OP_READ_ZERO;
            else if (row_unwritten)
                push_word.op = OP_READ_BLANK;
            else
                push_word.op = OP_READ_CELL;
        end
        else
        begin
            unique case (req.char_code)
                CH_NEWLINE:   push_word.op = OP_NEWLINE;
                CH_RETURN:    push_word.op = OP_RETURN;
                CH_TAB:       push_word.op = OP_TAB;
                CH_BACKSPACE: push_word.op = OP_BACKSPACE;
                CH_BELL:      push_word.op = OP_NOP;
                default:      push_word.op = OP_PLAIN;
            endcase
        end
    end

endmodule

[rtl/core/tcw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcw_pkg::cmd_word_t  push_word,
    input  logic                pop,
    output logic                not_empty,
    output logic                full,
    output tcw_pkg::cmd_word_t  head
);
    import tcw_pkg::*;

    cmd_word_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

endmodule

[rtl/core/tcw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands: cursor, cell store, scroll sweep and response register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 24,
    parameter int TAB_SPACES  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  tcw_pkg::cmd_word_t  cmd,
    output logic                cmd_pop,
    output logic                clearing,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcw_pkg::rsp_word_t  rsp
);
    import tcw_pkg::*;

    localparam int CELLS      = SCROLL_ROWS * COLUMNS;
    localparam int MOVE_CELLS = (SCROLL_ROWS - 1) * COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int ROW_W      = $clog2(SCROLL_ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int TAB_W      = $clog2(TAB_SPACES + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_TAB    = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;

    logic [15:0]      cell_mem [CELLS];
    logic [15:0]      mem_rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [ROW_W-1:0] cur_row_reg;
    logic [ROW_W-1:0] cur_row_next;
    logic [COL_W-1:0] cur_col_reg;
    logic [COL_W-1:0] cur_col_next;
    logic [TAB_W-1:0] tab_left_reg;
    logic [TAB_W-1:0] tab_left_next;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_next;
    logic             wr_pend_reg;
    logic             wr_pend_next;
    logic [AW-1:0]    wr_addr_reg;
    logic [AW-1:0]    wr_addr_next;
    logic             wr_blank_reg;
    logic             wr_blank_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;

    logic             finish;
    logic [15:0]      finish_cell;
    logic [AW-1:0]    cursor_addr;
    logic [AW-1:0]    read_addr;
    logic             at_right;
    logic             at_bottom;
    logic [ROW_W-1:0] nl_row;
    logic [COL_W-1:0] plain_col;
    logic [ROW_W-1:0] plain_row;
    logic             plain_scroll;
    logic [31:0]      row_wide;
    logic [31:0]      col_wide;

    assign clearing  = state_reg == ST_CLEAR;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // cursor addressing and one plain step
    assign cursor_addr  = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cur_col_reg);
    assign read_addr    = AW'(cmd.read_row) * AW'(COLUMNS) + AW'(cmd.read_col);
    assign at_right     = cur_col_reg == COL_W'(COLUMNS - 1);
    assign at_bottom    = cur_row_reg == ROW_W'(SCROLL_ROWS - 1);
    assign nl_row       = at_bottom ? cur_row_reg : cur_row_reg + 1'b1;
    assign plain_col    = at_right ? '0 : cur_col_reg + 1'b1;
    assign plain_row    = at_right ? nl_row : cur_row_reg;
    assign plain_scroll = at_right && at_bottom;

    // cursor as it stands after the current step, widened for the port fields
    assign row_wide = 32'(cur_row_next);
    assign col_wide = 32'(cur_col_next);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        tab_left_next  = tab_left_reg;
        idx_next       = idx_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_blank_next  = wr_blank_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = cursor_addr;
        mem_wdata      = BLANK_CELL;
        mem_re         = 1'b0;
        mem_raddr      = read_addr;
        cmd_pop        = 1'b0;
        finish         = 1'b0;
        finish_cell    = '0;

        // delayed write of the scroll sweep
        if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_blank_reg ? BLANK_CELL : mem_rdata_reg;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = BLANK_CELL;
                if (idx_reg == AW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_valid && !rsp_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_READ_CELL:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = read_addr;
                            state_next = ST_READ;
                        end
                        OP_READ_BLANK:
                        begin
                            finish      = 1'b1;
                            finish_cell = BLANK_CELL;
                        end
                        OP_NEWLINE:
                        begin
                            cur_col_next = '0;
                            cur_row_next = nl_row;
                            if (at_bottom)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                                finish = 1'b1;
                        end
                        OP_RETURN:
                        begin
                            cur_col_next = '0;
                            finish       = 1'b1;
                        end
                        OP_BACKSPACE:
                        begin
                            if (cur_col_reg != '0)
                                cur_col_next = cur_col_reg - 1'b1;
                            finish = 1'b1;
                        end
                        OP_TAB:
                        begin
                            tab_left_next = TAB_W'(TAB_SPACES);
                            state_next    = ST_TAB;
                        end
                        OP_PLAIN:
                        begin
                            mem_we       = 1'b1;
                            mem_waddr    = cursor_addr;
                            mem_wdata    = ATTR_NORMAL | {8'h00, cmd.char_code};
                            cur_col_next = plain_col;
                            cur_row_next = plain_row;
                            if (plain_scroll)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                                finish = 1'b1;
                        end
                        default:
                        begin
                            // out-of-range read, bell
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                finish      = 1'b1;
                finish_cell = mem_rdata_reg;
                state_next  = ST_IDLE;
            end
            ST_TAB:
            begin
                mem_we        = 1'b1;
                mem_waddr     = cursor_addr;
                mem_wdata     = ATTR_NORMAL | {8'h00, CH_SPACE};
                cur_col_next  = plain_col;
                cur_row_next  = plain_row;
                tab_left_next = tab_left_reg - 1'b1;
                if (plain_scroll)
                begin
                    idx_next   = '0;
                    state_next = ST_SCROLL;
                end
                else if (tab_left_reg == TAB_W'(1))
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                // read one row ahead, write it back in the following cycle
                if (idx_reg < AW'(MOVE_CELLS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(COLUMNS);
                end
                wr_pend_next  = 1'b1;
                wr_addr_next  = idx_reg;
                wr_blank_next = idx_reg >= AW'(MOVE_CELLS);
                if (idx_reg == AW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (tab_left_reg != '0)
                    state_next = ST_TAB;
                else
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // load the response word
        if (finish)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.cell_value = finish_cell;
            rsp_next.cursor_row = row_wide[4:0];
            rsp_next.cursor_col = col_wide[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_row_reg   <= ROW_W'(1);
            cur_col_reg   <= '0;
            tab_left_reg  <= '0;
            idx_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            tab_left_reg  <= tab_left_next;
            idx_reg       <= idx_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        wr_blank_reg <= wr_blank_next;
        rsp_reg      <= rsp_next;
    end

    // cell store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= cell_mem[mem_raddr];
    end

endmodule
